@@ src/ece_pkg.sv @@
// Shared types, constants and the elastic curve table for the easing curve evaluator.
// Used by every module under src except ece_ram; depends on nothing else.
`default_nettype none

package ece_pkg;

    // Port widths
    localparam int ALPHA_W = 16;
    localparam int CURVE_W = 3;
    localparam int EASED_W = 16;

    // Fixed point format and table size
    localparam int FRAC_BITS   = 15;
    localparam int TABLE_BITS  = 10;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;

    // Internal widths
    localparam int A_W    = FRAC_BITS + 1;      // saturated alpha, 0..ONE
    localparam int OPND_W = FRAC_BITS + 5;      // squarer operand, holds 22*alpha
    localparam int PROD_W = 2 * OPND_W;         // full square
    localparam int RES_W  = FRAC_BITS + 2;      // base plus rounded square

    localparam logic [A_W-1:0]    ONE       = A_W'(1) << FRAC_BITS;
    localparam logic [A_W-1:0]    HALF      = A_W'(1) << (FRAC_BITS - 1);
    localparam logic [EASED_W-1:0] EASED_MAX = '1;

    // Bounce segment limits on 11*alpha and segment offsets
    localparam logic [OPND_W-1:0] BNC_LIM1 = OPND_W'(4) << FRAC_BITS;
    localparam logic [OPND_W-1:0] BNC_LIM2 = OPND_W'(8) << FRAC_BITS;
    localparam logic [OPND_W-1:0] BNC_LIM3 = OPND_W'(10) << FRAC_BITS;
    localparam logic [OPND_W-1:0] BNC_M2   = OPND_W'(12) << FRAC_BITS;
    localparam logic [OPND_W-1:0] BNC_M3   = OPND_W'(18) << FRAC_BITS;
    localparam logic [OPND_W-1:0] BNC_M4   = OPND_W'(21) << FRAC_BITS;
    localparam logic [A_W-1:0]    BNC_K2   = (ONE >> 2) * A_W'(3);
    localparam logic [A_W-1:0]    BNC_K3   = (ONE >> 4) * A_W'(15);
    localparam logic [A_W-1:0]    BNC_K4   = (ONE >> 6) * A_W'(63);

    // Curve codes
    typedef enum logic [CURVE_W-1:0] {
        CURVE_LINEAR   = 3'd0,
        CURVE_IN       = 3'd1,
        CURVE_OUT      = 3'd2,
        CURVE_IN_OUT   = 3'd3,
        CURVE_BOUNCE   = 3'd4,
        CURVE_ELASTIC  = 3'd5
    } curve_e;

    // How the final stage forms the result
    typedef enum logic [1:0] {
        OP_PASS = 2'd0,     // base only
        OP_ADD  = 2'd1,     // base + rounded square
        OP_SUB  = 2'd2,     // base - rounded square
        OP_ROM  = 2'd3      // elastic table entry
    } op_e;

    // Rounding shift applied to the square
    typedef enum logic [1:0] {
        SH_F   = 2'd0,
        SH_FM1 = 2'd1,
        SH_FP1 = 2'd2,
        SH_FP6 = 2'd3
    } shift_e;

    typedef struct packed {
        op_e                   op;
        shift_e                sh;
        logic [A_W-1:0]        base;
        logic [OPND_W-1:0]     u;
        logic [TABLE_BITS-1:0] idx;
    } s1_t;

    typedef struct packed {
        op_e               op;
        shift_e            sh;
        logic [A_W-1:0]    base;
        logic [PROD_W-1:0] prod;
    } s2_t;

    typedef logic [EASED_W-1:0] elastic_rom_t [TABLE_DEPTH];

    // Round half up and drop s bits; s is a constant at every call site
    function automatic logic [PROD_W:0] round_shift(input logic [PROD_W-1:0] p,
                                                    input int unsigned s);
        logic [PROD_W:0] sum;
        sum = {1'b0, p} + ((PROD_W + 1)'(1) << (s - 1));
        return sum >> s;
    endfunction

    // Q30 helpers for building the elastic table at elaboration
    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] Q30_MASK  = Q30_ONE - 64'd1;
    localparam logic [63:0] Q28_ONE   = 64'd1 << 28;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [63:0] TWOPI_Q30 = 64'd6746518852;

    // One table entry: 1 + 2^(-t) * sin((t - 0.75) * 2pi/3), t = 10*idx/DEPTH
    function automatic logic [EASED_W-1:0] elastic_entry(input logic [TABLE_BITS-1:0] idx);
        logic [63:0] t;
        logic [63:0] k;
        logic [63:0] y;
        logic [63:0] p;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] ph;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic [63:0] v;
        logic        neg;
        int          n;
        t = ((64'd10 * 64'(idx)) << 30) >> TABLE_BITS;

        // exponent factor, series of exp(-f*ln2), then shift by the integer part
        k = t >> 30;
        y = ((t & Q30_MASK) * LN2_Q30) >> 30;
        term = Q30_ONE;
        s = Q30_ONE;
        for (n = 1; n <= 10; n++) begin
            p = (term * y) >> 30;
            unique case (n)
                1:       term = p / 64'd1;
                2:       term = p / 64'd2;
                3:       term = p / 64'd3;
                4:       term = p / 64'd4;
                5:       term = p / 64'd5;
                6:       term = p / 64'd6;
                7:       term = p / 64'd7;
                8:       term = p / 64'd8;
                9:       term = p / 64'd9;
                default: term = p / 64'd10;
            endcase
            if (n % 2 == 1) begin
                s = s - term;
            end
            else begin
                s = s + term;
            end
        end
        e = s >> k[3:0];

        // sine factor: phase in turns, folded to the first quadrant
        ph = ((t + (64'd9 << 28)) / 64'd3) & Q30_MASK;
        q = (ph >> 28) & 64'd3;
        r = ph & (Q28_ONE - 64'd1);
        if (q[0]) begin
            r = Q28_ONE - r;
        end
        x = (r * TWOPI_Q30) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        s = x;
        for (n = 1; n <= 7; n++) begin
            p = (term * x2) >> 30;
            unique case (n)
                1:       term = p / 64'd6;
                2:       term = p / 64'd20;
                3:       term = p / 64'd42;
                4:       term = p / 64'd72;
                5:       term = p / 64'd110;
                6:       term = p / 64'd156;
                default: term = p / 64'd210;
            endcase
            if (n % 2 == 1) begin
                s = (s > term) ? s - term : 64'd0;
            end
            else begin
                s = s + term;
            end
        end
        neg = (q >= 64'd2);

        mag = (e * s) >> 30;
        if (neg) begin
            v = (mag >= Q30_ONE) ? 64'd0 : Q30_ONE - mag;
        end
        else begin
            v = Q30_ONE + mag;
        end
        v = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (v > 64'(EASED_MAX)) begin
            v = 64'(EASED_MAX);
        end
        return v[EASED_W-1:0];
    endfunction

    function automatic elastic_rom_t build_elastic_rom();
        elastic_rom_t rom;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            rom[i] = elastic_entry(TABLE_BITS'(i));
        end
        return rom;
    endfunction

    localparam elastic_rom_t ELASTIC_ROM = build_elastic_rom();

endpackage

`default_nettype wire

@@ src/ece_ram.sv @@
// Generic simple dual port RAM: one write port, one read port with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ece_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/ece_table.sv @@
// Elastic curve table: RAM plus the load sequencer that copies the constant table in after reset.
// Depends on ece_pkg and ece_ram.
`default_nettype none

module ece_table (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             rd_en,
    input  wire logic [ece_pkg::TABLE_BITS-1:0]   rd_addr,
    output      logic [ece_pkg::EASED_W-1:0]      rd_data,
    output      logic                             busy
);

    logic [ece_pkg::TABLE_BITS:0]   cnt_reg;
    logic [ece_pkg::TABLE_BITS:0]   cnt_next;
    logic                           we_reg;
    logic                           we_next;
    logic [ece_pkg::TABLE_BITS-1:0] wa_reg;
    logic [ece_pkg::EASED_W-1:0]    wd_reg;
    logic                           loading;

    // Top bit of the counter marks the end of the sweep
    assign loading  = !cnt_reg[ece_pkg::TABLE_BITS];
    assign cnt_next = loading ? cnt_reg + (ece_pkg::TABLE_BITS + 1)'(1) : cnt_reg;
    assign we_next  = loading;
    assign busy     = loading || we_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            we_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            we_reg  <= we_next;
        end
    end

    // Register the constant entry, write it the cycle after
    always_ff @(posedge clk)
    begin
        if (loading)
        begin
            wa_reg <= cnt_reg[ece_pkg::TABLE_BITS-1:0];
            wd_reg <= ece_pkg::ELASTIC_ROM[cnt_reg[ece_pkg::TABLE_BITS-1:0]];
        end
    end

    ece_ram #(
        .WIDTH (ece_pkg::EASED_W),
        .DEPTH (ece_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we_reg),
        .waddr (wa_reg),
        .wdata (wd_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

endmodule

`default_nettype wire

@@ src/ece_front.sv @@
// First pipeline stage: saturate alpha, decode the curve, form the squarer operand.
// Depends on ece_pkg.
`default_nettype none

module ece_front (
    input  wire logic                         clk,
    input  wire logic                         ld,
    input  wire logic [ece_pkg::ALPHA_W-1:0]  alpha,
    input  wire logic [ece_pkg::CURVE_W-1:0]  curve,
    output      ece_pkg::s1_t                 s1
);

    ece_pkg::s1_t                   s1_reg;
    ece_pkg::s1_t                   s1_next;
    logic [ece_pkg::A_W-1:0]        a_sat;
    logic [ece_pkg::OPND_W-1:0]     a11;
    logic [ece_pkg::OPND_W-1:0]     a22;
    logic [ece_pkg::OPND_W-1:0]     m_one;
    logic [ece_pkg::A_W-1:0]        k_off;

    always_comb
    begin
        a_sat = (alpha > ece_pkg::ALPHA_W'(ece_pkg::ONE)) ? ece_pkg::ONE
                                                        : ece_pkg::A_W'(alpha);
        a11   = ece_pkg::OPND_W'(a_sat) * ece_pkg::OPND_W'(11);
        a22   = a11 << 1;

        // Bounce segment select
        priority if (a11 < ece_pkg::BNC_LIM1)
        begin
            m_one = '0;
            k_off = '0;
        end
        else if (a11 < ece_pkg::BNC_LIM2)
        begin
            m_one = ece_pkg::BNC_M2;
            k_off = ece_pkg::BNC_K2;
        end
        else if (a11 < ece_pkg::BNC_LIM3)
        begin
            m_one = ece_pkg::BNC_M3;
            k_off = ece_pkg::BNC_K3;
        end
        else
        begin
            m_one = ece_pkg::BNC_M4;
            k_off = ece_pkg::BNC_K4;
        end

        s1_next.op   = ece_pkg::OP_PASS;
        s1_next.sh   = ece_pkg::SH_F;
        s1_next.base = a_sat;
        s1_next.u    = ece_pkg::OPND_W'(a_sat);
        s1_next.idx  = a_sat[ece_pkg::FRAC_BITS-1 -: ece_pkg::TABLE_BITS];

        unique case (ece_pkg::curve_e'(curve))
            ece_pkg::CURVE_IN:
            begin
                s1_next.op   = ece_pkg::OP_ADD;
                s1_next.base = '0;
            end
            ece_pkg::CURVE_OUT:
            begin
                s1_next.op   = ece_pkg::OP_SUB;
                s1_next.base = ece_pkg::ONE;
                s1_next.u    = ece_pkg::OPND_W'(ece_pkg::ONE - a_sat);
            end
            ece_pkg::CURVE_IN_OUT:
            begin
                if (a_sat < ece_pkg::HALF)
                begin
                    s1_next.op   = ece_pkg::OP_ADD;
                    s1_next.sh   = ece_pkg::SH_FM1;
                    s1_next.base = '0;
                end
                else
                begin
                    s1_next.op   = ece_pkg::OP_SUB;
                    s1_next.sh   = ece_pkg::SH_FP1;
                    s1_next.base = ece_pkg::ONE;
                    s1_next.u    = ece_pkg::OPND_W'(ece_pkg::ONE - a_sat) << 1;
                end
            end
            ece_pkg::CURVE_BOUNCE:
            begin
                s1_next.op   = ece_pkg::OP_ADD;
                s1_next.sh   = ece_pkg::SH_FP6;
                s1_next.base = k_off;
                s1_next.u    = (a22 >= m_one) ? a22 - m_one : m_one - a22;
            end
            ece_pkg::CURVE_ELASTIC:
            begin
                // Endpoints are exact; everything between comes from the table
                if (a_sat == '0)
                begin
                    s1_next.base = '0;
                end
                else if (a_sat != ece_pkg::ONE)
                begin
                    s1_next.op = ece_pkg::OP_ROM;
                end
            end
            default:
            begin
                s1_next.op = ece_pkg::OP_PASS;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

@@ src/ece_back.sv @@
// Second and third pipeline stages: square the operand, then round, combine and saturate.
// Depends on ece_pkg.
`default_nettype none

module ece_back (
    input  wire logic                         clk,
    input  wire logic                         ld2,
    input  wire logic                         ld3,
    input  wire ece_pkg::s1_t                 s1,
    input  wire logic [ece_pkg::EASED_W-1:0]  rom_data,
    output      logic [ece_pkg::EASED_W-1:0]  eased
);

    ece_pkg::s2_t                  s2_reg;
    logic [ece_pkg::PROD_W:0]      rnd_full;
    logic [ece_pkg::A_W-1:0]       rnd;
    logic [ece_pkg::RES_W-1:0]     res;
    logic [ece_pkg::EASED_W-1:0]   eased_reg;
    logic [ece_pkg::EASED_W-1:0]   eased_next;

    // Stage 2: one square per item
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_reg.op   <= s1.op;
            s2_reg.sh   <= s1.sh;
            s2_reg.base <= s1.base;
            s2_reg.prod <= ece_pkg::PROD_W'(s1.u) * ece_pkg::PROD_W'(s1.u);
        end
    end

    // Stage 3: round the square, apply it to the base
    always_comb
    begin
        unique case (s2_reg.sh)
            ece_pkg::SH_F:   rnd_full = ece_pkg::round_shift(s2_reg.prod, ece_pkg::FRAC_BITS);
            ece_pkg::SH_FM1: rnd_full = ece_pkg::round_shift(s2_reg.prod,
                                                             ece_pkg::FRAC_BITS - 1);
            ece_pkg::SH_FP1: rnd_full = ece_pkg::round_shift(s2_reg.prod,
                                                             ece_pkg::FRAC_BITS + 1);
            default:         rnd_full = ece_pkg::round_shift(s2_reg.prod,
                                                             ece_pkg::FRAC_BITS + 6);
        endcase
        rnd = rnd_full[ece_pkg::A_W-1:0];

        unique case (s2_reg.op)
            ece_pkg::OP_ADD: res = ece_pkg::RES_W'(s2_reg.base) + ece_pkg::RES_W'(rnd);
            ece_pkg::OP_SUB: res = ece_pkg::RES_W'(s2_reg.base) - ece_pkg::RES_W'(rnd);
            ece_pkg::OP_ROM: res = ece_pkg::RES_W'(rom_data);
            default:         res = ece_pkg::RES_W'(s2_reg.base);
        endcase

        if (res > ece_pkg::RES_W'(ece_pkg::EASED_MAX))
        begin
            eased_next = ece_pkg::EASED_MAX;
        end
        else
        begin
            eased_next = res[ece_pkg::EASED_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            eased_reg <= eased_next;
        end
    end

    assign eased = eased_reg;

endmodule

`default_nettype wire

@@ src/easing_curve_evaluator.sv @@
// Top level of the easing curve evaluator: valid/ready control of the three stage pipeline.
// Depends on ece_pkg, ece_front, ece_back and ece_table.
//
// Usage:
//   Input channel (in_valid/in_ready) carries alpha, unsigned Q1.15 progress, and curve,
//   the curve code: linear, quadratic ease-in, ease-out, ease-in-out, bounce ease-out,
//   elastic ease-out; codes 6 and 7 act as linear. Alpha above 1.0 saturates to 1.0.
//   Output channel (out_valid/out_ready) carries eased, unsigned Q1.15, one result
//   per input transfer, in order.
// Pipeline: an accepted item moves through the stage 1, stage 2 and stage 3 registers
//   in turn, and out_valid rises once it reaches stage 3.
//   Stage 1 saturates and decodes, stage 2 squares (one 20x20 multiplier) and reads the
//   elastic table RAM, stage 3 rounds, combines and holds the result.
// Throughput: one item per cycle while out_ready is high. Each stage loads whenever it is
//   empty or the stage after it moves on, so the pipeline compacts while out_ready is low
//   and only backs up to in_ready once all three stages hold an item.
// Reset: rst_n clears all valid bits. The elastic table RAM is then loaded from the
//   constant table, one entry per cycle, after reset is released; in_ready stays low
//   until the last entry has been written.
// Stall: while out_ready is low the held result stays put and items in flight move up
//   only into empty stages; nothing is dropped or repeated.
`default_nettype none

module easing_curve_evaluator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output      logic                         in_ready,
    input  wire logic [ece_pkg::ALPHA_W-1:0]  alpha,
    input  wire logic [ece_pkg::CURVE_W-1:0]  curve,
    output      logic                         out_valid,
    input  wire logic                         out_ready,
    output      logic [ece_pkg::EASED_W-1:0]  eased
);

    logic                        v1_reg;
    logic                        v1_next;
    logic                        v2_reg;
    logic                        v2_next;
    logic                        v3_reg;
    logic                        v3_next;
    logic                        adv1;
    logic                        adv2;
    logic                        adv3;
    logic                        ld1;
    logic                        ld2;
    logic                        ld3;
    logic                        tbl_busy;
    ece_pkg::s1_t                s1;
    logic [ece_pkg::EASED_W-1:0] rom_data;

    // A stage may load when it is empty or its contents advance this cycle
    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    // Hold off input until the table load is done
    assign in_ready = adv1 && !tbl_busy;

    assign ld1 = in_valid && in_ready;
    assign ld2 = adv2 && v1_reg;
    assign ld3 = adv3 && v2_reg;

    assign v1_next = adv1 ? ld1 : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    ece_front u_front (
        .clk   (clk),
        .ld    (ld1),
        .alpha (alpha),
        .curve (curve),
        .s1    (s1)
    );

    // Table read is issued as stage 1 moves into stage 2, so the data lines up with stage 2
    ece_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ld2),
        .rd_addr (s1.idx),
        .rd_data (rom_data),
        .busy    (tbl_busy)
    );

    ece_back u_back (
        .clk      (clk),
        .ld2      (ld2),
        .ld3      (ld3),
        .s1       (s1),
        .rom_data (rom_data),
        .eased    (eased)
    );

    assign out_valid = v3_reg;

    // No transfer is taken while the table is loading
    a_no_accept_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_busy |-> !in_ready)
        else $error("input accepted during table load");

    // Pipeline is empty for the whole table load
    a_empty_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_busy |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("item in flight during table load");

    // A blocked stage 1 keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv2) |=> (v1_reg && $stable(s1)))
        else $error("stage 1 item lost under stall");

    // An item leaving stage 2 lands in the output stage
    a_s2_to_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && adv3) |=> v3_reg)
        else $error("stage 2 item dropped");

endmodule

`default_nettype wire

@@ sim/easing_curve_evaluator_tb.sv @@
// Self-checking testbench for easing_curve_evaluator: valid/ready driver, monitor and
// a bit-exact predictor of every easing curve, including the elastic table.
// Depends on src/ece_pkg.sv and the RTL under src.
`default_nettype none

module easing_curve_evaluator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = ece_pkg::FRAC_BITS;
    localparam int TB = ece_pkg::TABLE_BITS;

    // Codes 6 and 7 have no name in the package; the block treats them as linear
    localparam logic [ece_pkg::CURVE_W-1:0] CURVE_SPARE_6 = 3'd6;
    localparam logic [ece_pkg::CURVE_W-1:0] CURVE_SPARE_7 = 3'd7;

    // Fixed point constants of the predictor
    localparam logic [63:0] UNIT       = 64'd1 << FB;
    localparam logic [63:0] Q30_UNIT   = 64'd1 << 30;
    localparam logic [63:0] Q30_FRAC   = Q30_UNIT - 64'd1;
    localparam logic [63:0] QUAD_TURN  = 64'd1 << 28;
    localparam logic [63:0] LN_TWO_Q30 = 64'd744261118;
    localparam logic [63:0] TAU_Q30    = 64'd6746518852;

    localparam int SETTLE_CYCLES = 10;

    // One pending transfer on the input side; a pause entry holds the sender
    // until every outstanding result has come back
    typedef struct {
        logic [ece_pkg::ALPHA_W-1:0] alpha;
        logic [ece_pkg::CURVE_W-1:0] curve;
        int unsigned                 gap;
        bit                          pause;
    } sample_req_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [ece_pkg::ALPHA_W-1:0]   alpha = '0;
    logic [ece_pkg::CURVE_W-1:0]   curve = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [ece_pkg::EASED_W-1:0]   eased;

    sample_req_t                   sample_queue[$];
    logic [ece_pkg::EASED_W-1:0]   eased_fifo[$];

    int unsigned item_total = 0;
    int unsigned accepted_count = 0;
    int unsigned gap_count = 0;
    int unsigned stall_left = 0;
    int unsigned stall_pct = 0;
    int unsigned cycle_no = 0;
    int unsigned fail_count = 0;

    easing_curve_evaluator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .alpha     (alpha),
        .curve     (curve),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .eased     (eased)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half up, then drop s bits
    function automatic logic [63:0] round_up_shift(input logic [63:0] x, input int unsigned s);
        return (x + (64'd1 << (s - 1))) >> s;
    endfunction

    // 2^(-t) in Q30 for t in Q30: series of exp(-f*ln2) on the fraction,
    // then shift by the integer part
    function automatic logic [63:0] decay_q30(input logic [63:0] t);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] acc;
        int          n;
        y = ((t & Q30_FRAC) * LN_TWO_Q30) >> 30;
        term = Q30_UNIT;
        acc = Q30_UNIT;
        for (n = 1; n <= 10; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc >> t[33:30];
    endfunction

    // Sine magnitude in Q30 of a phase in Q30 turns; fold into the first quadrant
    function automatic logic [63:0] wave_q30(input logic [63:0] ph, output logic neg);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        int          n;
        quad = ph[29:28];
        r = ph & (QUAD_TURN - 64'd1);
        if (quad[0])
            r = QUAD_TURN - r;
        x = (r * TAU_Q30) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = (acc > term) ? acc - term : 64'd0;
            else
                acc = acc + term;
        end
        neg = quad[1];
        return acc;
    endfunction

    // Elastic ease-out: exact at both ends, table entry by the top alpha bits otherwise
    function automatic logic [63:0] elastic_q(input logic [63:0] a);
        logic [63:0] slot;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] s;
        logic [63:0] mag;
        logic [63:0] v;
        logic        neg;
        if (a == 64'd0)
            return 64'd0;
        if (a >= UNIT)
            return UNIT;
        slot = (a << TB) >> FB;
        t = ((64'd10 * slot) << 30) >> TB;
        e = decay_q30(t);
        s = wave_q30(((t + (64'd9 << 28)) / 64'd3) & Q30_FRAC, neg);
        mag = (e * s) >> 30;
        if (neg)
            v = (mag >= Q30_UNIT) ? 64'd0 : Q30_UNIT - mag;
        else
            v = Q30_UNIT + mag;
        return round_up_shift(v, 30 - FB);
    endfunction

    // Bounce ease-out: four parabolic segments, (22a - m)^2 / 64 plus the segment floor
    function automatic logic [63:0] bounce_q(input logic [63:0] a);
        logic [63:0] m;
        logic [63:0] k;
        logic [63:0] u;
        if (64'd11 * a < 64'd4 * UNIT) begin
            m = 64'd0;
            k = 64'd0;
        end
        else if (64'd11 * a < 64'd8 * UNIT) begin
            m = 64'd12;
            k = (UNIT >> 2) * 64'd3;
        end
        else if (64'd11 * a < 64'd10 * UNIT) begin
            m = 64'd18;
            k = (UNIT >> 4) * 64'd15;
        end
        else begin
            m = 64'd21;
            k = (UNIT >> 6) * 64'd63;
        end
        u = (64'd22 * a >= m * UNIT) ? 64'd22 * a - m * UNIT : m * UNIT - 64'd22 * a;
        return round_up_shift(u * u, FB + 6) + k;
    endfunction

    // Eased value that one input transfer must produce
    function automatic logic [ece_pkg::EASED_W-1:0] eased_of(
        input logic [ece_pkg::ALPHA_W-1:0] a_in,
        input logic [ece_pkg::CURVE_W-1:0] c_in
    );
        logic [63:0] a;
        logic [63:0] d;
        logic [63:0] r;
        a = 64'(a_in);
        if (a > UNIT)
            a = UNIT;
        case (c_in)
            ece_pkg::CURVE_IN:
                r = round_up_shift(a * a, FB);
            ece_pkg::CURVE_OUT: begin
                d = UNIT - a;
                r = UNIT - round_up_shift(d * d, FB);
            end
            ece_pkg::CURVE_IN_OUT: begin
                if (a < (UNIT >> 1)) begin
                    r = round_up_shift(a * a, FB - 1);
                end
                else begin
                    d = 64'd2 * (UNIT - a);
                    r = UNIT - round_up_shift(d * d, FB + 1);
                end
            end
            ece_pkg::CURVE_BOUNCE:
                r = bounce_q(a);
            ece_pkg::CURVE_ELASTIC:
                r = elastic_q(a);
            default:
                r = a;
        endcase
        if (r > 64'(ece_pkg::EASED_MAX))
            r = 64'(ece_pkg::EASED_MAX);
        return r[ece_pkg::EASED_W-1:0];
    endfunction

    // Idle length: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_sample(input logic [ece_pkg::ALPHA_W-1:0] a,
                              input logic [ece_pkg::CURVE_W-1:0] c,
                              input int unsigned gap);
        sample_req_t req;
        req.alpha = a;
        req.curve = c;
        req.gap = gap;
        req.pause = 1'b0;
        sample_queue.push_back(req);
        item_total++;
    endtask

    task automatic add_pause();
        sample_req_t req;
        req.alpha = '0;
        req.curve = '0;
        req.gap = 0;
        req.pause = 1'b1;
        sample_queue.push_back(req);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the head of sample_queue, hold it until the transfer,
    // and record the predicted result at the accepting edge
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive
        sample_req_t head;
        if (!rst_n) begin
            in_valid <= 1'b0;
            alpha <= '0;
            curve <= '0;
            gap_count <= 0;
        end
        else begin
            // Values seen here are the ones the block sampled at this edge
            if (in_valid && in_ready) begin
                eased_fifo.push_back(eased_of(alpha, curve));
                accepted_count++;
            end
            // Load a new item only when nothing is held for the block
            if (!in_valid || in_ready) begin
                if (sample_queue.size() == 0) begin
                    in_valid <= 1'b0;
                end
                else if (sample_queue[0].pause) begin
                    // Hold off until the pipeline has drained completely
                    in_valid <= 1'b0;
                    if (eased_fifo.size() == 0)
                        void'(sample_queue.pop_front());
                end
                else if (gap_count < sample_queue[0].gap) begin
                    in_valid <= 1'b0;
                    gap_count <= gap_count + 1;
                end
                else begin
                    head = sample_queue.pop_front();
                    in_valid <= 1'b1;
                    alpha <= head.alpha;
                    curve <= head.curve;
                    gap_count <= 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each output transfer against the oldest prediction and
    // stall out_ready at random, with calm and busy stretches
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : observe
        logic [ece_pkg::EASED_W-1:0] want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
            stall_pct <= 0;
            cycle_no <= 0;
        end
        else begin
            cycle_no <= cycle_no + 1;
            if (out_valid && out_ready) begin
                if (eased_fifo.size() == 0) begin
                    $error("result with nothing outstanding: eased=%0d", eased);
                    fail_count++;
                end
                else begin
                    want = eased_fifo.pop_front();
                    if (eased !== want) begin
                        $error("eased: expected %0d, actual %0d", want, eased);
                        fail_count++;
                    end
                end
            end
            // Pick a new stall density periodically by cycle_no; zero gives a calm stretch
            if (cycle_no % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct <= 0;
                    1: stall_pct <= 15;
                    default: stall_pct <= 50;
                endcase
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [ece_pkg::ALPHA_W-1:0] a;
        int unsigned                 pick;
        bit                          calm;

        // Every curve code at alpha zero, the unnamed ones included
        add_sample(16'd0, ece_pkg::CURVE_LINEAR, pick_gap());
        add_sample(16'd0, ece_pkg::CURVE_IN, pick_gap());
        add_sample(16'd0, ece_pkg::CURVE_OUT, pick_gap());
        add_sample(16'd0, ece_pkg::CURVE_IN_OUT, pick_gap());
        add_sample(16'd0, ece_pkg::CURVE_BOUNCE, pick_gap());
        add_sample(16'd0, ece_pkg::CURVE_ELASTIC, pick_gap());
        add_sample(16'd0, CURVE_SPARE_6, pick_gap());
        add_sample(16'd0, CURVE_SPARE_7, pick_gap());
        // Saturation above one, unnamed code passing alpha through
        add_sample(16'hFFFF, CURVE_SPARE_7, pick_gap());
        add_sample(16'd32769, ece_pkg::CURVE_IN, pick_gap());
        add_sample(16'hFFFF, ece_pkg::CURVE_OUT, pick_gap());
        // Elastic: exact one, just below one, inside the first table entry, next entry
        add_sample(16'd32768, ece_pkg::CURVE_ELASTIC, pick_gap());
        add_sample(16'd32767, ece_pkg::CURVE_ELASTIC, pick_gap());
        add_sample(16'd1, ece_pkg::CURVE_ELASTIC, pick_gap());
        add_sample(16'd31, ece_pkg::CURVE_ELASTIC, pick_gap());
        add_sample(16'd32, ece_pkg::CURVE_ELASTIC, pick_gap());
        // Ease-in-out either side of the half point
        add_sample(16'd16383, ece_pkg::CURVE_IN_OUT, pick_gap());
        add_sample(16'd16384, ece_pkg::CURVE_IN_OUT, pick_gap());
        // Bounce segment edges and the top
        add_sample(16'd11915, ece_pkg::CURVE_BOUNCE, pick_gap());
        add_sample(16'd11916, ece_pkg::CURVE_BOUNCE, pick_gap());
        add_sample(16'd23831, ece_pkg::CURVE_BOUNCE, pick_gap());
        add_sample(16'd23832, ece_pkg::CURVE_BOUNCE, pick_gap());
        add_sample(16'd29789, ece_pkg::CURVE_BOUNCE, pick_gap());
        add_sample(16'd29790, ece_pkg::CURVE_BOUNCE, pick_gap());
        add_sample(16'd32768, ece_pkg::CURVE_BOUNCE, pick_gap());
        add_pause();

        // Random part; every 50 items decide whether the sender idles at all
        calm = 1'b0;
        for (int i = 0; i < 500; i++) begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (i == 250)
                add_pause();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                a = ece_pkg::ALPHA_W'($urandom_range(0, 32768));
            else if (pick < 80)
                a = ece_pkg::ALPHA_W'($urandom_range(32769, 65535));
            else if (pick < 90)
                a = ece_pkg::ALPHA_W'($urandom_range(0, 40));
            else
                a = ece_pkg::ALPHA_W'($urandom_range(32700, 32768));
            add_sample(a, ece_pkg::CURVE_W'($urandom_range(0, 7)), calm ? 0 : pick_gap());
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to transfer and every result to come back
        do
            @(posedge clk);
        while (accepted_count != item_total || eased_fifo.size() != 0);
        // Give a stray extra result time to show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
src/ece_pkg.sv
src/ece_ram.sv
src/ece_table.sv
src/ece_front.sv
src/ece_back.sv
src/easing_curve_evaluator.sv
sim/easing_curve_evaluator_tb.sv
